// ===== design/lzbd_pkg.sv =====
// lzbd_pkg: shared types and constants of the lz block decompressor
// used by every module under design/
package lzbd_pkg;

  localparam int HistBytes = 131072;
  localparam int HistAw    = $clog2(HistBytes);
  localparam int LaneBytes = 8;
  localparam logic [23:0] TailMargin = 24'd11;

  typedef enum logic [1:0] {
    PH_CWORD = 2'd0,
    PH_ITEM  = 2'd1,
    PH_TOKEN = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_MATCH = 2'd2
  } cmd_kind_t;

  // one command from the parser to the copy engine
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  lit;
    logic [17:0] off;
    logic [8:0]  len;
    logic        frame_start;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RUN  = 2'd1,
    BK_WAIT = 2'd2
  } back_state_t;

  function automatic logic [2:0] token_len(input logic [7:0] first);
    if (first[1:0] == 2'b00) begin
      token_len = 3'd1;
    end else if (first[1:0] != 2'b11) begin
      token_len = 3'd2;
    end else if (first[6:0] != 7'd3) begin
      token_len = 3'd3;
    end else begin
      token_len = 3'd4;
    end
  endfunction

endpackage

// ===== design/lzbd_parser.sv =====
// lzbd_parser: front part; gathers control words and tokens, issues commands
// depends on lzbd_pkg
module lzbd_parser import lzbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic [23:0] output_size,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] tok_r, tok_nxt;
  logic [2:0]  gath_r, gath_nxt;
  logic [23:0] pos_r, pos_nxt;
  logic        tail_r, tail_nxt;

  logic [31:0] ctrl_c, tok_c, tok_full;
  logic [2:0]  gath_c;
  logic [23:0] pos_c;
  logic        tail_c;
  phase_t      phase_c;
  logic [17:0] m_off;
  logic [8:0]  m_len;
  logic [24:0] pos_sum;
  logic [23:0] room;
  logic        fire, issue;

  assign in_ready = cmd_ready;
  assign fire = in_valid && in_ready;

  // frame start clears state before the byte is used
  always_comb begin
    phase_c = frame_start ? PH_CWORD : phase_r;
    ctrl_c  = frame_start ? 32'd1 : ctrl_r;
    tok_c   = frame_start ? 32'd0 : tok_r;
    gath_c  = frame_start ? 3'd0 : gath_r;
    pos_c   = frame_start ? 24'd0 : pos_r;
    tail_c  = frame_start ? 1'b0 : tail_r;
  end

  always_comb begin
    tok_full = tok_c;
    unique case (gath_c[1:0])
      2'd0: tok_full[7:0]   = tok_c[7:0]   | data_byte;
      2'd1: tok_full[15:8]  = tok_c[15:8]  | data_byte;
      2'd2: tok_full[23:16] = tok_c[23:16] | data_byte;
      default: tok_full[31:24] = tok_c[31:24] | data_byte;
    endcase
  end

  // match decode of the full token (one byte forms land here too)
  logic [31:0] f;
  always_comb begin
    f = (phase_c == PH_TOKEN) ? tok_full : {24'd0, data_byte};
    if (f[1:0] == 2'b00) begin
      m_off = {12'd0, f[7:2]};
      m_len = 9'd3;
    end else if (f[1] == 1'b0) begin
      m_off = {4'd0, f[15:2]};
      m_len = 9'd3;
    end else if (f[0] == 1'b0) begin
      m_off = {8'd0, f[15:6]};
      m_len = {5'd0, f[5:2]} + 9'd3;
    end else if (f[6:0] != 7'd3) begin
      m_off = {1'b0, f[23:7]};
      m_len = {4'd0, f[6:2]} + 9'd2;
    end else begin
      m_off = {1'b0, f[31:15]};
      m_len = {1'b0, f[14:7]} + 9'd3;
    end
  end

  always_comb begin
    phase_nxt = phase_c;
    ctrl_nxt  = ctrl_c;
    tok_nxt   = tok_c;
    gath_nxt  = gath_c;
    pos_nxt   = pos_c;
    tail_nxt  = tail_c;
    issue     = 1'b0;
    cmd       = '0;
    cmd.frame_start = frame_start;
    cmd.off   = m_off;
    cmd.len   = m_len;
    pos_sum   = {1'b0, pos_c} + {1'b0, TailMargin};
    room      = output_size - pos_c;
    if (pos_c < output_size) begin
      unique case (phase_c)
        PH_CWORD: begin
          tok_nxt  = tok_full;
          gath_nxt = gath_c + 3'd1;
          if (gath_c == 3'd3) begin
            ctrl_nxt  = tok_full;
            tok_nxt   = '0;
            gath_nxt  = '0;
            phase_nxt = PH_ITEM;
          end
        end
        PH_SKIP: begin
          gath_nxt = gath_c + 3'd1;
          if (gath_c == 3'd3) begin
            gath_nxt  = '0;
            ctrl_nxt  = 32'h8000_0000;
            phase_nxt = PH_ITEM;
          end
        end
        PH_TOKEN: begin
          tok_nxt  = tok_full;
          gath_nxt = gath_c + 3'd1;
          if (gath_c + 3'd1 >= token_len(tok_full[7:0])) begin
            issue     = 1'b1;
            cmd.kind  = CMD_MATCH;
            tok_nxt   = '0;
            gath_nxt  = '0;
            ctrl_nxt  = ctrl_c >> 1;
          end
        end
        default: begin
          if (!tail_c && ctrl_c[0]) begin
            if (token_len(data_byte) == 3'd1) begin
              issue    = 1'b1;
              cmd.kind = CMD_MATCH;
              ctrl_nxt = ctrl_c >> 1;
            end else begin
              tok_nxt   = {24'd0, data_byte};
              gath_nxt  = 3'd1;
              phase_nxt = PH_TOKEN;
            end
          end else begin
            if (pos_sum >= {1'b0, output_size}) tail_nxt = 1'b1;
            issue    = 1'b1;
            cmd.kind = CMD_LIT;
            cmd.lit  = data_byte;
            cmd.len  = 9'd1;
            ctrl_nxt = ctrl_c >> 1;
          end
        end
      endcase
      if (issue) begin
        // parser tracks position so the tail rule can be applied up front
        if ({15'd0, cmd.len} > room) pos_nxt = output_size;
        else pos_nxt = pos_c + {15'd0, cmd.len};
        if (ctrl_nxt == 32'd1) phase_nxt = tail_nxt ? PH_SKIP : PH_CWORD;
        else phase_nxt = PH_ITEM;
      end
    end
    // frame start must reach the back end even without bytes
    cmd_valid = in_valid && (issue || frame_start);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CWORD;
      ctrl_r  <= 32'd1;
      tok_r   <= '0;
      gath_r  <= '0;
      pos_r   <= '0;
      tail_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      ctrl_r  <= ctrl_nxt;
      tok_r   <= tok_nxt;
      gath_r  <= gath_nxt;
      pos_r   <= pos_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

// ===== design/lzbd_fifo.sv =====
// lzbd_fifo: two-entry command queue between parser and copy engine
// depends on lzbd_pkg
module lzbd_fifo import lzbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== design/lzbd_copy.sv =====
// lzbd_copy: back part; history memory, byte copy and lane packing
// depends on lzbd_pkg
module lzbd_copy import lzbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [23:0] output_size,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata
);

  back_state_t st_r, st_nxt;
  logic [7:0]   hist [HistBytes];
  logic [23:0]  prod_r;
  logic [8:0]   left_r;
  logic         bad_r, lit_r, rd_pend_r;
  logic [7:0]   lit_byte_r;
  logic [17:0]  off_r;
  logic [7:0]   rdata_r;
  logic [63:0]  lane_r;
  logic [3:0]   fill_r;
  logic         ov_r;
  logic [71:0]  obuf_r;
  logic [HistAw-1:0] raddr;
  logic [7:0]   b;
  logic         step, out_free, last_byte, full, bad_c;
  logic [23:0]  prod_c;

  // one byte at a time: history read registered, byte taken once the output is free
  assign out_free  = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = obuf_r;
  assign cmd_ready  = (st_r == BK_IDLE);
  assign prod_c = cmd.frame_start ? 24'd0 : prod_r;
  assign bad_c  = (cmd.off == 18'd0) || ({6'd0, cmd.off} > prod_c) ||
                  (cmd.off > 18'(HistBytes));

  always_comb begin
    raddr = HistAw'(prod_r - {6'd0, off_r});
    b = lit_r ? lit_byte_r : (bad_r ? 8'd0 : rdata_r);
    last_byte = (left_r == 9'd1) || (prod_r + 24'd1 >= output_size);
    full = (fill_r == 4'(LaneBytes - 1));
    step = (st_r == BK_RUN) && rd_pend_r && out_free;
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (cmd_valid && cmd.kind != CMD_NONE && prod_c < output_size) st_nxt = BK_RUN;
      BK_RUN:  if (step && last_byte) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rd_pend_r || step) rdata_r <= hist[raddr];
    if (step) hist[HistAw'(prod_r)] <= b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      prod_r <= '0;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      fill_r <= '0;
      lane_r <= '0;
      left_r <= '0;
      bad_r <= 1'b0;
      lit_r <= 1'b0;
      lit_byte_r <= '0;
      off_r <= '0;
      obuf_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (step && (full || last_byte)) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      if (st_r == BK_IDLE && cmd_valid) begin
        prod_r <= prod_c;
        left_r <= cmd.len;
        lit_r  <= cmd.kind == CMD_LIT;
        lit_byte_r <= cmd.lit;
        off_r  <= cmd.off;
        bad_r  <= (cmd.kind == CMD_MATCH) && bad_c;
        rd_pend_r <= 1'b0;
        fill_r <= '0;
        lane_r <= '0;
      end else if (st_r == BK_RUN) begin
        if (step) begin
          rd_pend_r <= 1'b0;
          prod_r <= prod_r + 24'd1;
          left_r <= left_r - 9'd1;
          if (full || last_byte) begin
            obuf_r[63:0] <= lane_r | ({56'd0, b} << (fill_r[2:0]*8));
            obuf_r[67:64] <= fill_r + 4'd1;
            obuf_r[68] <= last_byte;
            obuf_r[69] <= last_byte && (prod_r + 24'd1 >= output_size);
            obuf_r[70] <= bad_r;
            obuf_r[71] <= 1'b0;
            fill_r <= '0;
            lane_r <= '0;
          end else begin
            lane_r[fill_r[2:0]*8 +: 8] <= b;
            fill_r <= fill_r + 4'd1;
          end
        end else begin
          rd_pend_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lz_block_decompressor.sv =====
// channel | dir | fields (low bit first)
// in_     | in  | tdata: data_byte[7:0]; tuser: frame_start
// out_    | out | tdata: out_bytes[63:0], byte_count[67:64], run_last[68],
//         |     |        frame_done[69], offset_error[70], zero pad
// cfg_    | in  | output_size[23:0]
// the copy engine accepts a literal or match command while idle; for each byte it reads
// the history memory, then writes the byte to the history and the output lane, one byte
// per step, and takes no new command before the last byte. a full output word stalls
// the copy engine until taken. the parser accepts bytes only while the two-entry command
// queue has room; the queue lets the parser run ahead of the copy engine.
// reset is synchronous active low; history is not cleared.
module lz_block_decompressor import lzbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_bytes, byte_count, run_last, frame_done,
                                  // offset_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // output_size
);

  logic [23:0] size_r;
  logic        pv, pr, cv, cr;
  cmd_t        pc, cc;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 24'd11;
    else if (cfg_valid) size_r <= cfg_data;
  end

  lzbd_parser u_parse (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata), .frame_start(in_tuser), .output_size(size_r),
    .cmd_valid(pv), .cmd_ready(pr), .cmd(pc)
  );

  lzbd_fifo u_q (
    .clk, .rst_n, .wr_valid(pv), .wr_ready(pr), .wr_data(pc),
    .rd_valid(cv), .rd_ready(cr), .rd_data(cc)
  );

  lzbd_copy u_copy (
    .clk, .rst_n, .cmd_valid(cv), .cmd_ready(cr), .cmd(cc),
    .output_size(size_r), .out_tvalid, .out_tready, .out_tdata
  );

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] != 4'd0 && out_tdata[67:64] <= 4'd8))
    else $error("byte count out of range");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[69]) |-> out_tdata[68])
    else $error("frame done without run end");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for lz_block_decompressor
// drives compressed words, predicts the decompressed output words, checks them
// depends on design/lzbd_pkg.sv and design/lz_block_decompressor.sv
module tb_top;
  import lzbd_pkg::*;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        run_last;
    logic        frame_done;
    logic        offset_error;
  } out_word_t;

  class lz_scoreboard;
    logic [7:0]  hist [HistBytes];
    logic [23:0] out_size;
    logic [31:0] ctrl;
    logic [31:0] tok;
    int unsigned gathered;
    logic [23:0] produced;
    phase_t      phase;
    bit          tail;
    out_word_t   pending [$];
    out_word_t   step_words [$];
    logic [63:0] lane;
    int unsigned fill;
    int          errors;

    function new();
      out_size = 24'd11;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ctrl = 32'd1;
      tok = '0;
      gathered = 0;
      produced = '0;
      phase = PH_CWORD;
      tail = 1'b0;
    endfunction

    function int unsigned tok_bytes(logic [7:0] f);
      case (f[1:0])
        2'b00: return 1;
        2'b01, 2'b10: return 2;
        default: return (f[6:2] == 5'd0) ? 4 : 3;
      endcase
    endfunction

    function void flush_lane();
      out_word_t w;
      if (fill == 0) return;
      w.bytes = lane;
      w.count = 4'(fill);
      w.run_last = 1'b0;
      w.frame_done = 1'b0;
      w.offset_error = 1'b0;
      step_words.push_back(w);
      lane = '0;
      fill = 0;
    endfunction

    function void emit_byte(logic [7:0] b);
      if (produced >= out_size) return;
      hist[produced[16:0]] = b;
      produced++;
      lane |= 64'(b) << (8 * fill);
      fill++;
      if (fill >= LaneBytes) flush_lane();
    endfunction

    function bit copy_match(logic [31:0] f);
      logic [31:0] off;
      logic [31:0] len;
      logic [7:0]  b;
      bit bad;
      if (f[1:0] == 2'b00) begin
        off = 32'(f[7:2]);
        len = 3;
      end else if (f[1:0] == 2'b01) begin
        off = 32'(f[15:2]);
        len = 3;
      end else if (f[1:0] == 2'b10) begin
        off = 32'(f[15:6]);
        len = 32'(f[5:2]) + 3;
      end else if (f[6:2] != 5'd0) begin
        off = 32'(f[23:7]);
        len = 32'(f[6:2]) + 2;
      end else begin
        off = 32'(f[31:15]);
        len = 32'(f[14:7]) + 3;
      end
      bad = (off == 0) || (off > 32'(produced)) || (off > HistBytes);
      for (int i = 0; i < len; i++) begin
        b = 8'h00;
        if (!bad) b = hist[17'(32'(produced) - off)];
        emit_byte(b);
      end
      return bad;
    endfunction

    function void advance();
      if (ctrl == 32'd1) phase = tail ? PH_SKIP : PH_CWORD;
      else phase = PH_ITEM;
    endfunction

    // works out the output words caused by one accepted compressed word
    function void note_input(logic [7:0] b, logic fs);
      bit err;
      err = 1'b0;
      step_words.delete();
      lane = '0;
      fill = 0;
      if (fs) clear_frame();
      if (produced >= out_size) return;
      case (phase)
        PH_CWORD: begin
          tok |= 32'(b) << (8 * (gathered % 4));
          gathered++;
          if (gathered >= 4) begin
            ctrl = tok;
            tok = '0;
            gathered = 0;
            phase = PH_ITEM;
          end
        end
        PH_SKIP: begin
          gathered++;
          if (gathered >= 4) begin
            gathered = 0;
            ctrl = 32'h8000_0000;
            phase = PH_ITEM;
          end
        end
        PH_TOKEN: begin
          tok |= 32'(b) << (8 * (gathered % 4));
          gathered++;
          if (gathered >= tok_bytes(tok[7:0])) begin
            err = copy_match(tok);
            tok = '0;
            gathered = 0;
            ctrl >>= 1;
            advance();
          end
        end
        default: begin
          if (!tail && ctrl[0]) begin
            if (tok_bytes(b) == 1) begin
              err = copy_match(32'(b));
              ctrl >>= 1;
              advance();
            end else begin
              tok = 32'(b);
              gathered = 1;
              phase = PH_TOKEN;
            end
          end else begin
            if (32'(produced) + 32'(TailMargin) >= 32'(out_size)) tail = 1'b1;
            emit_byte(b);
            ctrl >>= 1;
            advance();
          end
        end
      endcase
      flush_lane();
      foreach (step_words[k]) step_words[k].offset_error = err;
      if (step_words.size() > 0) begin
        step_words[$].run_last = 1'b1;
        step_words[$].frame_done = (produced >= out_size);
      end
      foreach (step_words[k]) pending.push_back(step_words[k]);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_word(logic [71:0] d);
      out_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output word %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.bytes)
        report($sformatf("out_bytes %h, expected %h", d[63:0], e.bytes));
      if (d[67:64] !== e.count)
        report($sformatf("byte_count %0d, expected %0d", d[67:64], e.count));
      if (d[68] !== e.run_last)
        report($sformatf("run_last %b, expected %b", d[68], e.run_last));
      if (d[69] !== e.frame_done)
        report($sformatf("frame_done %b, expected %b", d[69], e.frame_done));
      if (d[70] !== e.offset_error)
        report($sformatf("offset_error %b, expected %b", d[70], e.offset_error));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // out_bytes, byte_count, run_last, frame_done, offset_error
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;   // output_size

  lz_scoreboard sb;
  logic [7:0] queued_bytes [$];
  bit          hold_req;
  int          hold_left;
  int unsigned cyc;
  int          idle_cycles;
  int          burst_left;

  localparam int IdleLimit = 5000;
  localparam int SettleCycles = 64;

  lz_block_decompressor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (hold_req && hold_left == 0) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case ((cyc / 256) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task send_word(logic [7:0] b, logic fs);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b, fs);
  endtask

  task pause_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task drain_outputs();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task write_size(logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.out_size = v;
    cfg_valid <= 1'b0;
  endtask

  task plan_control_word(output logic [7:0] b);
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'd1;
      1: w = 32'd0;
      2: w = 32'hffff_ffff;
      default: w = $urandom;
    endcase
    b = w[7:0];
    queued_bytes.push_back(w[15:8]);
    queued_bytes.push_back(w[23:16]);
    queued_bytes.push_back(w[31:24]);
  endtask

  task plan_match(output logic [7:0] b);
    int unsigned p, form, maxoff, off, len, nb;
    logic [31:0] f;
    p = 32'(sb.produced);
    form = $urandom_range(0, 4);
    case (form)
      0: maxoff = 63;
      1: maxoff = 16383;
      2: maxoff = 1023;
      default: maxoff = 131071;
    endcase
    if (p == 0 || $urandom_range(0, 9) == 0)
      off = (p + 1 <= maxoff && $urandom_range(0, 1)) ? p + 1 : 0;
    else
      off = $urandom_range(1, (p < maxoff) ? p : maxoff);
    case (form)
      0: begin f = off << 2; nb = 1; end
      1: begin f = (off << 2) | 1; nb = 2; end
      2: begin
        len = $urandom_range(3, 18);
        f = (off << 6) | ((len - 3) << 2) | 2;
        nb = 2;
      end
      3: begin
        len = $urandom_range(3, 33);
        f = (off << 7) | ((len - 2) << 2) | 3;
        nb = 3;
      end
      default: begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 258) : $urandom_range(3, 20);
        f = (off << 15) | ((len - 3) << 7) | 3;
        nb = 4;
      end
    endcase
    b = f[7:0];
    for (int i = 1; i < nb; i++) queued_bytes.push_back(8'(f >> (8 * i)));
  endtask

  // next compressed word: mostly well-formed, with some noise
  task plan_word(output logic [7:0] b);
    if ($urandom_range(0, 19) == 0) begin
      queued_bytes.delete();
      b = 8'($urandom);
    end else if (queued_bytes.size() != 0) begin
      b = queued_bytes.pop_front();
    end else if (sb.phase == PH_CWORD) begin
      plan_control_word(b);
    end else if (sb.phase == PH_ITEM && !sb.tail && sb.ctrl[0]) begin
      plan_match(b);
    end else begin
      b = 8'($urandom);
    end
  endtask

  task run_phase(logic [23:0] size, int budget, bit with_hold);
    int n;
    bit fs, live;
    logic [7:0] b;
    drain_outputs();
    write_size(size);
    n = 0;
    fs = 1'b1;
    while (n < budget) begin
      if (fs) begin
        queued_bytes.delete();
        plan_control_word(b);
      end else begin
        plan_word(b);
      end
      live = fs || (sb.produced < sb.out_size);
      send_word(b, fs);
      if (live) n++;
      if (with_hold && n == budget / 3) hold_req = 1'b1;
      if (n == budget / 2) begin
        in_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      fs = (sb.produced >= sb.out_size && $urandom_range(0, 3) != 0) ||
           ($urandom_range(0, 199) == 0);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end
  endtask

  // hand-built frames: every token form, overlap, overrun, bad offset,
  // ignored word after completion, a control word of one
  localparam logic [8:0] Directed [37] = '{
    9'h1F8, 9'h001, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h05A, 9'h004,
    9'h009, 9'h000, 9'h07E, 9'h000, 9'h07F, 9'h001, 9'h000,
    9'h083, 9'h07F, 9'h001, 9'h000, 9'h011,
    9'h102, 9'h000, 9'h000, 9'h080, 9'h077, 9'h000, 9'h0C3,
    9'h101, 9'h000, 9'h000, 9'h000, 9'h0AB, 9'h000, 9'h000, 9'h000, 9'h000, 9'h012
  };

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    hold_left = 0;
    cyc = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(24'd300);
    foreach (Directed[i]) send_word(Directed[i][7:0], Directed[i][8]);

    run_phase(24'd11, 40, 1'b0);
    run_phase(24'hff_ffff, 50, 1'b0);
    run_phase(24'd40, 70, 1'b1);
    run_phase(24'd12, 30, 1'b0);
    run_phase(24'd200, 90, 1'b0);
    run_phase(24'($urandom_range(13, 120)), 70, 1'b0);
    run_phase(24'($urandom_range(100, 2000)), 70, 1'b0);

    drain_outputs();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/lzbd_pkg.sv
design/lzbd_parser.sv
design/lzbd_fifo.sv
design/lzbd_copy.sv
design/lz_block_decompressor.sv
verif/tb_top.sv
